/* hw/rtl/tlik_pkg.sv */
// shared constants, register codes and the cordic angle table for the two-link ik controller
package tlik_pkg;

	localparam int CORDIC_STEPS = 16;
	localparam int ANGLE_WIDTH = 16;

	// angle accumulator fraction bits and width
	localparam int ZFRAC = ANGLE_WIDTH - 3;
	localparam int ZW = ZFRAC + 5;
	localparam int CIW = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;

	// rounding of the accumulator to q2.13
	localparam int RSH = (ZFRAC > 13) ? ZFRAC - 13 : 0;
	localparam int LSH = (ZFRAC < 13) ? 13 - ZFRAC : 0;
	localparam int RND = (1 << RSH) >> 1;

	localparam int C_FRAC = 28;
	localparam int ANGLE_LIMIT = 25736;
	localparam int TORQUE_MAX = 8388607;
	localparam int TORQUE_MIN = -8388608;

	// serial multiplier: radix-16 digits over a 32 bit multiplier operand
	localparam int MB_W = 32;
	localparam int DIGIT_W = 4;
	localparam int MUL_DIGITS = MB_W / DIGIT_W;

	localparam logic signed [ZW-1:0] PI_Z = ZW'(34'd3373259426 >> (30 - ZFRAC));

	typedef enum logic [2:0] {
		REG_TARGET_X    = 3'd0,
		REG_TARGET_Y    = 3'd1,
		REG_UPPER_LEN   = 3'd2,
		REG_LOWER_LEN   = 3'd3,
		REG_POS_GAIN    = 3'd4,
		REG_DAMP_GAIN   = 3'd5
	} cfg_reg_t;

	function automatic logic signed [ZW-1:0] cordic_angle(input logic [CIW-1:0] idx);
		logic [31:0] t;
		case (idx)
			0: t = 32'h3243F6A8;
			1: t = 32'h1DAC6705;
			2: t = 32'h0FADBAFC;
			3: t = 32'h07F56EA6;
			4: t = 32'h03FEAB76;
			5: t = 32'h01FFD55B;
			6: t = 32'h00FFFAAA;
			7: t = 32'h007FFF55;
			8: t = 32'h003FFFEA;
			9: t = 32'h001FFFFD;
			10: t = 32'h000FFFFF;
			11: t = 32'h0007FFFF;
			12: t = 32'h0003FFFF;
			13: t = 32'h0001FFFF;
			14: t = 32'h0000FFFF;
			15: t = 32'h00007FFF;
			16: t = 32'h00003FFF;
			17: t = 32'h00001FFF;
			18: t = 32'h00000FFF;
			19: t = 32'h000007FF;
			20: t = 32'h000003FF;
			21: t = 32'h000001FF;
			22: t = 32'h000000FF;
			23: t = 32'h0000007F;
			default: t = 32'h0;
		endcase
		return ZW'(t >> (30 - ZFRAC));
	endfunction

endpackage

/* hw/rtl/two_link_ik_pd_joint_control.sv */
// two-link planar inverse kinematics with pd joint torque control
// Each input word (shoulder and elbow angle) yields one result word: the inverse
// kinematics targets for the configured point (elbow-down), a reach flag and the
// saturated pd torques of both joints. Work runs one word at a time through a
// sequencer that shares one radix-16 serial multiplier (a load step, the eight
// digits in turn and a post step per product), a one-bit-per-cycle restoring
// divider, a one-bit-per-cycle square root and an iterative vectoring cordic.
// A new word is taken as soon as the sequencer is idle, even while the
// previous result still sits in the output register. The configuration
// port is always ready; write registers only while idle.
module two_link_ik_pd_joint_control
	import tlik_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [15:0] shoulder_angle,
	input  logic signed [15:0] elbow_angle,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [23:0] shoulder_torque,
	output logic signed [23:0] elbow_torque,
	output logic signed [15:0] shoulder_target,
	output logic signed [15:0] elbow_target,
	output logic               target_reachable,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [15:0]        cfg_data
);

	typedef enum logic [3:0] {
		ST_IDLE, ST_LOAD, ST_MUL, ST_POST, ST_DIV, ST_SQRT,
		ST_CINIT, ST_CRUN, ST_CEND, ST_DONE
	} state_t;

	// products handed to the shared multiplier, in running order
	typedef enum logic [4:0] {
		OP_PX2, OP_PY2, OP_REACH, OP_L12, OP_NUM1, OP_NUM2, OP_C2SQ,
		OP_K1, OP_K2, OP_Y1, OP_Y2, OP_X1, OP_X2, OP_TS1, OP_TS2, OP_TE1, OP_TE2
	} op_t;

	localparam int MCW = $clog2(MUL_DIGITS);

	state_t state_q;
	op_t    op_q;

	// configuration
	logic signed [15:0] px_q, py_q;
	logic [13:0]        l1_q, l2_q, kp_q, kd_q;

	// word in flight and history
	logic signed [15:0] as_q, ae_q, prev_s_q, prev_e_q;

	// multiplier
	logic signed [63:0] ma_q, acc_q;
	logic [MB_W-1:0]    mb_q;
	logic [MCW-1:0]     mcnt_q;

	// kinematics intermediates
	logic signed [63:0] r2_q, reach_q, k1_q, k2_q, y_q;
	logic [29:0]        den_q;
	logic               ok_q;
	logic [30:0]        rem_q;
	logic [C_FRAC-1:0]  quo_q;
	logic [4:0]         dcnt_q;
	logic               neg_q;
	logic signed [29:0] c2_q;
	logic [57:0]        sv_q, sr_q, sb_q;
	logic [28:0]        s_q;

	// cordic
	logic signed [63:0] cx_q, cy_q;
	logic signed [ZW-1:0] cz_q;
	logic [CIW-1:0]     ci_q;
	logic               czero_q, celbow_q;

	logic signed [15:0] th1_q, th2_q;
	logic signed [23:0] ts_q, te_q;

	// output register
	logic               out_valid_q;
	logic signed [23:0] ost_q, oet_q;
	logic signed [15:0] osg_q, oeg_q;
	logic               ook_q;

	// operand selection
	logic signed [31:0] l1_w, l2_w, lsum_w, px_w, py_w;
	logic signed [63:0] op_a, op_init;
	logic signed [31:0] op_b;

	assign l1_w   = 32'($signed({1'b0, l1_q}));
	assign l2_w   = 32'($signed({1'b0, l2_q}));
	assign lsum_w = l1_w + l2_w;
	assign px_w   = 32'(px_q);
	assign py_w   = 32'(py_q);

	always_comb begin
		op_a    = '0;
		op_b    = '0;
		op_init = '0;
		unique case (op_q)
			OP_PX2: begin op_a = 64'(px_w); op_b = px_w; end
			OP_PY2: begin op_a = 64'(py_w); op_b = py_w; op_init = acc_q; end
			OP_REACH: begin op_a = 64'(lsum_w); op_b = lsum_w; end
			OP_L12: begin op_a = 64'(l1_w); op_b = l2_w; end
			OP_NUM1: begin op_a = 64'(l1_w); op_b = -l1_w; op_init = r2_q; end
			OP_NUM2: begin op_a = 64'(l2_w); op_b = -l2_w; op_init = acc_q; end
			OP_C2SQ: begin op_a = 64'(c2_q); op_b = 32'(c2_q); end
			OP_K1: begin
				op_a    = 64'(c2_q);
				op_b    = l2_w;
				op_init = 64'(l1_w) <<< C_FRAC;
			end
			OP_K2: begin op_a = 64'($signed({1'b0, s_q})); op_b = -l2_w; end
			OP_Y1: begin op_a = k1_q; op_b = py_w; end
			OP_Y2: begin op_a = k2_q; op_b = -px_w; op_init = acc_q; end
			OP_X1: begin op_a = k1_q; op_b = px_w; end
			OP_X2: begin op_a = k2_q; op_b = py_w; op_init = acc_q; end
			OP_TS1: begin
				op_a = 64'($signed({1'b0, kp_q}));
				op_b = 32'(th1_q) - 32'(as_q);
			end
			OP_TS2: begin
				op_a    = 64'($signed({1'b0, kd_q}));
				op_b    = 32'(prev_s_q) - 32'(as_q);
				op_init = acc_q;
			end
			OP_TE1: begin
				op_a = 64'($signed({1'b0, kp_q}));
				op_b = 32'(th2_q) - 32'(ae_q);
			end
			OP_TE2: begin
				op_a    = 64'($signed({1'b0, kd_q}));
				op_b    = 32'(prev_e_q) - 32'(ae_q);
				op_init = acc_q;
			end
			default: ;
		endcase
	end

	// one digit of the multiplier per cycle, top digit signed
	logic               mlast;
	logic signed [4:0]  mdig;
	logic signed [63:0] mprod;

	assign mlast = (mcnt_q == MCW'(MUL_DIGITS - 1));
	assign mdig  = $signed({mlast & mb_q[DIGIT_W-1], mb_q[DIGIT_W-1:0]});
	assign mprod = ma_q * mdig;

	// torque rounding and saturation of the accumulated pd sum
	logic signed [63:0] tq_w;
	logic signed [23:0] tq_sat;

	assign tq_w = (acc_q + 64'sd128) >>> 8;
	always_comb begin
		if (tq_w > 64'(TORQUE_MAX))
			tq_sat = 24'(TORQUE_MAX);
		else if (tq_w < 64'(TORQUE_MIN))
			tq_sat = 24'(TORQUE_MIN);
		else
			tq_sat = tq_w[23:0];
	end

	// cosine numerator and clamp decisions
	logic signed [33:0] num_w, den_w;
	logic [30:0]        num_abs;

	assign num_w   = acc_q[33:0];
	assign den_w   = 34'($signed({1'b0, den_q}));
	assign num_abs = num_w[33] ? 31'(-num_w) : num_w[30:0];

	// divider step
	logic [31:0] rem_sh;
	logic        rem_ge;

	assign rem_sh = {rem_q, 1'b0};
	assign rem_ge = rem_sh >= {2'b0, den_q};

	// square root step
	logic [57:0] sqrt_rb, sqrt_r_nx;
	logic        sqrt_ge;

	assign sqrt_rb   = sr_q + sb_q;
	assign sqrt_ge   = sv_q >= sqrt_rb;
	assign sqrt_r_nx = sqrt_ge ? ((sr_q >> 1) + sb_q) : (sr_q >> 1);

	// cordic step and result rounding
	logic signed [63:0]    cxs, cys;
	logic signed [ZW-1:0]  cang;
	logic signed [ZW+15:0] czr;
	logic signed [15:0]    cres;

	assign cxs  = cx_q >>> ci_q;
	assign cys  = cy_q >>> ci_q;
	assign cang = cordic_angle(ci_q);
	assign czr  = ((ZW+16)'(cz_q) + (ZW+16)'(RND)) >>> RSH <<< LSH;

	always_comb begin
		if (czero_q)
			cres = '0;
		else if (czr > (ZW+16)'(ANGLE_LIMIT))
			cres = 16'(ANGLE_LIMIT);
		else if (czr < -(ZW+16)'(ANGLE_LIMIT))
			cres = -16'(ANGLE_LIMIT);
		else
			cres = czr[15:0];
	end

	logic out_free;
	assign out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			op_q        <= OP_PX2;
			px_q        <= 16'sd3277;
			py_q        <= '0;
			l1_q        <= 14'd1638;
			l2_q        <= 14'd1638;
			kp_q        <= 14'd2560;
			kd_q        <= 14'd256;
			prev_s_q    <= '0;
			prev_e_q    <= '0;
			as_q        <= '0;
			ae_q        <= '0;
			ma_q        <= '0;
			mb_q        <= '0;
			acc_q       <= '0;
			mcnt_q      <= '0;
			r2_q        <= '0;
			reach_q     <= '0;
			k1_q        <= '0;
			k2_q        <= '0;
			y_q         <= '0;
			den_q       <= '0;
			ok_q        <= 1'b0;
			rem_q       <= '0;
			quo_q       <= '0;
			dcnt_q      <= '0;
			neg_q       <= 1'b0;
			c2_q        <= '0;
			sv_q        <= '0;
			sr_q        <= '0;
			sb_q        <= '0;
			s_q         <= '0;
			cx_q        <= '0;
			cy_q        <= '0;
			cz_q        <= '0;
			ci_q        <= '0;
			czero_q     <= 1'b0;
			celbow_q    <= 1'b0;
			th1_q       <= '0;
			th2_q       <= '0;
			ts_q        <= '0;
			te_q        <= '0;
			out_valid_q <= 1'b0;
			ost_q       <= '0;
			oet_q       <= '0;
			osg_q       <= '0;
			oeg_q       <= '0;
			ook_q       <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;

			if (cfg_valid && cfg_ready) begin
				unique case (cfg_reg_t'(cfg_index))
					REG_TARGET_X:  px_q <= cfg_data;
					REG_TARGET_Y:  py_q <= cfg_data;
					REG_UPPER_LEN: l1_q <= cfg_data[13:0];
					REG_LOWER_LEN: l2_q <= cfg_data[13:0];
					REG_POS_GAIN:  kp_q <= cfg_data[13:0];
					REG_DAMP_GAIN: kd_q <= cfg_data[13:0];
					default: ;
				endcase
			end

			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						as_q    <= shoulder_angle;
						ae_q    <= elbow_angle;
						op_q    <= OP_PX2;
						state_q <= ST_LOAD;
					end
				end
				ST_LOAD: begin
					ma_q    <= op_a;
					mb_q    <= op_b;
					acc_q   <= op_init;
					mcnt_q  <= '0;
					state_q <= ST_MUL;
				end
				ST_MUL: begin
					acc_q  <= acc_q + mprod;
					ma_q   <= ma_q <<< DIGIT_W;
					mb_q   <= mb_q >> DIGIT_W;
					if (mlast) begin
						mcnt_q  <= '0;
						state_q <= ST_POST;
					end else begin
						mcnt_q <= mcnt_q + 1'b1;
					end
				end
				ST_POST: begin
					state_q <= ST_LOAD;
					unique case (op_q)
						OP_PX2: op_q <= OP_PY2;
						OP_PY2: begin r2_q <= acc_q; op_q <= OP_REACH; end
						OP_REACH: begin reach_q <= acc_q; op_q <= OP_L12; end
						OP_L12: begin
							den_q <= 30'(acc_q <<< 1);
							ok_q  <= r2_q < reach_q;
							if (r2_q < reach_q) begin
								op_q <= OP_NUM1;
							end else begin
								// out of reach: elbow straight, aim at the point
								th2_q    <= '0;
								cx_q     <= 64'(px_q);
								cy_q     <= 64'(py_q);
								celbow_q <= 1'b0;
								state_q  <= ST_CINIT;
							end
						end
						OP_NUM1: op_q <= OP_NUM2;
						OP_NUM2: begin
							op_q <= OP_C2SQ;
							if (den_q == '0 || num_w >= den_w) begin
								c2_q <= 30'sd1 <<< C_FRAC;
							end else if (num_w <= -den_w) begin
								c2_q <= -(30'sd1 <<< C_FRAC);
							end else begin
								rem_q   <= num_abs;
								neg_q   <= num_w[33];
								quo_q   <= '0;
								dcnt_q  <= '0;
								state_q <= ST_DIV;
							end
						end
						OP_C2SQ: begin
							sv_q    <= (58'd1 << 56) - 58'(acc_q);
							sr_q    <= '0;
							sb_q    <= 58'd1 << 56;
							state_q <= ST_SQRT;
						end
						OP_K1: begin k1_q <= acc_q; op_q <= OP_K2; end
						OP_K2: begin k2_q <= acc_q; op_q <= OP_Y1; end
						OP_Y1: op_q <= OP_Y2;
						OP_Y2: begin y_q <= acc_q; op_q <= OP_X1; end
						OP_X1: op_q <= OP_X2;
						OP_X2: begin
							cx_q     <= acc_q;
							cy_q     <= y_q;
							celbow_q <= 1'b0;
							state_q  <= ST_CINIT;
						end
						OP_TS1: op_q <= OP_TS2;
						OP_TS2: begin ts_q <= tq_sat; op_q <= OP_TE1; end
						OP_TE1: op_q <= OP_TE2;
						OP_TE2: begin te_q <= tq_sat; state_q <= ST_DONE; end
						default: state_q <= ST_IDLE;
					endcase
				end
				ST_DIV: begin
					if (dcnt_q == 5'(C_FRAC)) begin
						c2_q    <= neg_q ? -30'($signed({1'b0, quo_q}))
						                 : 30'($signed({1'b0, quo_q}));
						state_q <= ST_LOAD;
					end else begin
						if (rem_ge) begin
							rem_q <= 31'(rem_sh - {2'b0, den_q});
							quo_q <= {quo_q[C_FRAC-2:0], 1'b1};
						end else begin
							rem_q <= rem_sh[30:0];
							quo_q <= {quo_q[C_FRAC-2:0], 1'b0};
						end
						dcnt_q <= dcnt_q + 1'b1;
					end
				end
				ST_SQRT: begin
					if (sqrt_ge)
						sv_q <= sv_q - sqrt_rb;
					sr_q <= sqrt_r_nx;
					sb_q <= sb_q >> 2;
					if (sb_q[0]) begin
						// square root done: elbow angle from (c2, s)
						s_q      <= sqrt_r_nx[28:0];
						cx_q     <= 64'(c2_q);
						cy_q     <= 64'($signed({1'b0, sqrt_r_nx[28:0]}));
						celbow_q <= 1'b1;
						state_q  <= ST_CINIT;
					end
				end
				ST_CINIT: begin
					czero_q <= (cx_q == '0) && (cy_q == '0);
					ci_q    <= '0;
					if (cx_q < 0) begin
						// left half plane: turn by pi first
						cz_q <= (cy_q >= 0) ? PI_Z : -PI_Z;
						cx_q <= -cx_q;
						cy_q <= -cy_q;
					end else begin
						cz_q <= '0;
					end
					state_q <= ST_CRUN;
				end
				ST_CRUN: begin
					if (cy_q > 64'sd0) begin
						cx_q <= cx_q + cys;
						cy_q <= cy_q - cxs;
						cz_q <= cz_q + cang;
					end else begin
						cx_q <= cx_q - cys;
						cy_q <= cy_q + cxs;
						cz_q <= cz_q - cang;
					end
					ci_q <= ci_q + 1'b1;
					if (ci_q == CIW'(CORDIC_STEPS - 1))
						state_q <= ST_CEND;
				end
				ST_CEND: begin
					state_q <= ST_LOAD;
					if (celbow_q) begin
						th2_q <= -cres;
						op_q  <= OP_K1;
					end else begin
						th1_q <= cres;
						op_q  <= OP_TS1;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						ost_q       <= ts_q;
						oet_q       <= te_q;
						osg_q       <= th1_q;
						oeg_q       <= th2_q;
						ook_q       <= ok_q;
						prev_s_q    <= as_q;
						prev_e_q    <= ae_q;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign in_stall         = (state_q != ST_IDLE);
	assign cfg_ready        = 1'b1;
	assign out_valid        = out_valid_q;
	assign shoulder_torque  = ost_q;
	assign elbow_torque     = oet_q;
	assign shoulder_target  = osg_q;
	assign elbow_target     = oeg_q;
	assign target_reachable = ook_q;

	// an accepted word always starts the sequencer
	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> state_q == ST_LOAD && op_q == OP_PX2)
		else $error("accepted word did not start the sequence");

	// out of reach means a straight elbow
	a_reach_elbow: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !target_reachable |-> elbow_target == 16'sd0)
		else $error("elbow target nonzero for an unreachable point");

	// digit counter only moves inside a product
	a_mcnt_idle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ST_MUL |-> mcnt_q == '0)
		else $error("multiplier digit counter active outside a product");

	// a result is written only into a free output register
	a_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DONE && out_free |=> out_valid_q && state_q == ST_IDLE)
		else $error("result not delivered to output register");

endmodule

/* test/two_link_ik_pd_joint_control_tb.sv */
// testbench for the two-link ik pd joint controller: directed and random words against a predictor
`timescale 1ns / 1ps

module two_link_ik_pd_joint_control_tb;
	import tlik_pkg::*;

	// one result word as the block presents it
	typedef struct packed {
		logic signed [23:0] shoulder_torque;
		logic signed [23:0] elbow_torque;
		logic signed [15:0] shoulder_target;
		logic signed [15:0] elbow_target;
		logic               reachable;
	} joint_result_t;

	localparam int HOLD_CYCLES = 800;
	localparam int STALL_LIMIT = 6000;
	localparam int DRAIN_CYCLES = 400;
	localparam longint ONE_Q28 = 64'sd1 << C_FRAC;
	localparam longint ATAN_Q30 [24] = '{
		64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76, 64'h01FFD55B,
		64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF,
		64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF, 64'h00007FFF, 64'h00003FFF, 64'h00001FFF,
		64'h00000FFF, 64'h000007FF, 64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F
	};

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	logic signed [15:0] shoulder_angle;
	logic signed [15:0] elbow_angle;
	logic               out_valid;
	logic               out_stall;
	logic signed [23:0] shoulder_torque;
	logic signed [23:0] elbow_torque;
	logic signed [15:0] shoulder_target;
	logic signed [15:0] elbow_target;
	logic               target_reachable;
	logic               cfg_valid;
	logic               cfg_ready;
	logic [2:0]         cfg_index;
	logic [15:0]        cfg_data;

	two_link_ik_pd_joint_control uut (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.shoulder_angle   (shoulder_angle),
		.elbow_angle      (elbow_angle),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.shoulder_torque  (shoulder_torque),
		.elbow_torque     (elbow_torque),
		.shoulder_target  (shoulder_target),
		.elbow_target     (elbow_target),
		.target_reachable (target_reachable),
		.cfg_valid        (cfg_valid),
		.cfg_ready        (cfg_ready),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data)
	);

	// mirror of the block's registers and joint history
	logic signed [15:0] point_x, point_y;
	logic [13:0]        upper_len, lower_len, kp_gain, kd_gain;
	logic signed [15:0] last_shoulder, last_elbow;

	joint_result_t pending_results [$];
	int  error_count;
	int  words_sent;
	int  words_checked;
	int  reachable_seen;
	int  unreachable_seen;
	bit  idling_on;
	bit  hold_request;
	int  hold_left;
	int  quiet_cycles;

	// 2 ns clock
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// integer square root, floor
	function automatic longint floor_sqrt(input logic [63:0] v);
		logic [63:0] root, bitv;
		root = 0;
		bitv = 64'd1 << 62;
		while (bitv > v)
			bitv = bitv >> 2;
		while (bitv != 0) begin
			if (v >= root + bitv) begin
				v = v - (root + bitv);
				root = (root >> 1) + bitv;
			end else begin
				root = root >> 1;
			end
			bitv = bitv >> 2;
		end
		return longint'(root);
	endfunction

	function automatic longint limit(input longint v, input longint lo, input longint hi);
		return (v < lo) ? lo : ((v > hi) ? hi : v);
	endfunction

	// vectoring cordic atan2, result in q2.13 clamped to the angle range
	function automatic longint vector_angle(input longint y, input longint x);
		longint z, xs, ys, step;
		z = 0;
		if (x == 0 && y == 0)
			return 0;
		// left half plane: turn by pi first
		if (x < 0) begin
			z = (y >= 0) ? (64'sd3373259426 >>> (30 - ZFRAC))
			             : -(64'sd3373259426 >>> (30 - ZFRAC));
			x = -x;
			y = -y;
		end
		for (int i = 0; i < CORDIC_STEPS; i++) begin
			step = (i < 24) ? (ATAN_Q30[i] >>> (30 - ZFRAC)) : 0;
			xs = x >>> i;
			ys = y >>> i;
			if (y > 0) begin
				x = x + ys;
				y = y - xs;
				z = z + step;
			end else begin
				x = x - ys;
				y = y + xs;
				z = z - step;
			end
		end
		if (ZFRAC > 13)
			z = (z + (64'sd1 << (ZFRAC - 14))) >>> (ZFRAC - 13);
		else
			z = z <<< (13 - ZFRAC);
		return limit(z, -ANGLE_LIMIT, ANGLE_LIMIT);
	endfunction

	// pd torque, q.21 products rounded half up to q.13 then saturated
	function automatic longint joint_torque(input longint ang, input longint tgt,
	                                        input longint prev);
		longint sum;
		sum = -longint'(kp_gain) * (ang - tgt) - longint'(kd_gain) * (ang - prev);
		return limit((sum + 128) >>> 8, TORQUE_MIN, TORQUE_MAX);
	endfunction

	// ik targets plus torques for one word; advances the joint history
	function automatic joint_result_t solve_joints(input logic signed [15:0] sh,
	                                               input logic signed [15:0] el);
		joint_result_t r;
		longint px, py, l1, l2, r2, reach, num, den, c2, s, k1, k2, th1, th2;
		px = longint'(point_x);
		py = longint'(point_y);
		l1 = longint'(upper_len);
		l2 = longint'(lower_len);
		r2 = px * px + py * py;
		reach = (l1 + l2) * (l1 + l2);
		if (r2 < reach) begin
			num = r2 - l1 * l1 - l2 * l2;
			den = 2 * l1 * l2;
			if (den == 0 || num >= den)
				c2 = ONE_Q28;
			else if (num <= -den)
				c2 = -ONE_Q28;
			else
				c2 = (num * ONE_Q28) / den;
			s = floor_sqrt(64'(ONE_Q28) * 64'(ONE_Q28) - 64'(c2 * c2));
			th2 = limit(-vector_angle(s, c2), -ANGLE_LIMIT, ANGLE_LIMIT);
			k1 = l1 * ONE_Q28 + l2 * c2;
			k2 = -l2 * s;
			th1 = vector_angle(py * k1 - px * k2, px * k1 + py * k2);
		end else begin
			th2 = 0;
			th1 = vector_angle(py, px);
		end
		r.shoulder_torque = 24'(joint_torque(longint'(sh), th1, longint'(last_shoulder)));
		r.elbow_torque = 24'(joint_torque(longint'(el), th2, longint'(last_elbow)));
		r.shoulder_target = 16'(th1);
		r.elbow_target = 16'(th2);
		r.reachable = (r2 < reach);
		last_shoulder = sh;
		last_elbow = el;
		return r;
	endfunction

	// send one word, idling at random beforehand
	task automatic send_word(input logic signed [15:0] sh, input logic signed [15:0] el);
		if (idling_on && $urandom_range(99) < 29) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		in_valid <= 1'b1;
		shoulder_angle <= sh;
		elbow_angle <= el;
		do @(posedge clk); while (in_stall);
		pending_results.push_back(solve_joints(sh, el));
		words_sent++;
	endtask

	// lower valid and wait for every outstanding result
	task automatic drain_results();
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	// register write, only called while the block is idle
	task automatic write_reg(input logic [2:0] idx, input logic [15:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (cfg_reg_t'(idx))
			REG_TARGET_X:  point_x = value;
			REG_TARGET_Y:  point_y = value;
			REG_UPPER_LEN: upper_len = value[13:0];
			REG_LOWER_LEN: lower_len = value[13:0];
			REG_POS_GAIN:  kp_gain = value[13:0];
			REG_DAMP_GAIN: kd_gain = value[13:0];
			default: ;
		endcase
	endtask

	task automatic write_all(input logic [15:0] x, input logic [15:0] y,
	                         input logic [15:0] l1, input logic [15:0] l2,
	                         input logic [15:0] kp, input logic [15:0] kd);
		write_reg(REG_TARGET_X, x);
		write_reg(REG_TARGET_Y, y);
		write_reg(REG_UPPER_LEN, l1);
		write_reg(REG_LOWER_LEN, l2);
		write_reg(REG_POS_GAIN, kp);
		write_reg(REG_DAMP_GAIN, kd);
	endtask

	function automatic logic signed [15:0] any_angle();
		return 16'($signed($urandom_range(0, 2 * ANGLE_LIMIT)) - ANGLE_LIMIT);
	endfunction

	// reset settings, angle extremes
	task automatic test_angle_extremes();
		send_word(16'sd0, 16'sd0);
		send_word(16'(ANGLE_LIMIT), -16'(ANGLE_LIMIT));
		send_word(-16'(ANGLE_LIMIT), 16'(ANGLE_LIMIT));
		send_word(16'(ANGLE_LIMIT), 16'(ANGLE_LIMIT));
		send_word(-16'(ANGLE_LIMIT), -16'(ANGLE_LIMIT));
		send_word(16'sd1, -16'sd1);
		drain_results();
	endtask

	// out of reach, origin, zero link, left half plane, gain extremes, bad index
	task automatic test_special_points();
		// far corner, out of reach
		write_all(16'h7FFF, 16'h8000, 16'd1638, 16'd1638, 16'd16383, 16'd0);
		send_word(any_angle(), any_angle());
		send_word(any_angle(), any_angle());
		drain_results();
		// target at origin, inside reach: cosine clamps to -1
		write_all(16'h0000, 16'h0000, 16'd4000, 16'd4000, 16'd0, 16'd16383);
		send_word(16'(ANGLE_LIMIT), -16'(ANGLE_LIMIT));
		send_word(any_angle(), any_angle());
		drain_results();
		// origin with both links zero: out of reach, shoulder 0
		write_reg(REG_UPPER_LEN, 16'hC000);
		write_reg(REG_LOWER_LEN, 16'h0000);
		send_word(any_angle(), any_angle());
		drain_results();
		// zero upper link inside reach
		write_all(16'd500, 16'hFE00, 16'd0, 16'd1000, 16'd2560, 16'd256);
		send_word(any_angle(), any_angle());
		drain_results();
		// left half plane above and below the axis
		write_all(16'hF000, 16'd100, 16'd3000, 16'd2500, 16'd16383, 16'd16383);
		send_word(any_angle(), any_angle());
		drain_results();
		write_reg(REG_TARGET_Y, 16'hFF00);
		send_word(any_angle(), any_angle());
		drain_results();
		// unknown indexes must leave every register alone
		write_reg(3'd6, 16'hFFFF);
		write_reg(3'd7, 16'h5555);
		send_word(any_angle(), any_angle());
		send_word(any_angle(), any_angle());
		drain_results();
	endtask

	// receiver holds off long enough to back the block up
	task automatic test_backpressure();
		idling_on = 1'b0;
		hold_request = 1'b1;
		for (int i = 0; i < 40; i++)
			send_word(any_angle(), any_angle());
		drain_results();
		idling_on = 1'b1;
	endtask

	// random settings per phase, extremes among them, random words in each
	task automatic test_random_phases();
		logic [15:0] x, y, l1, l2;
		int span;
		for (int phase = 0; phase < 8; phase++) begin
			l1 = 16'($urandom_range(0, 65535));
			l2 = 16'($urandom_range(0, 65535));
			if (phase % 2 == 0) begin
				// point scaled inside the reach of the arm
				span = int'(l1[13:0]) + int'(l2[13:0]);
				x = 16'(($signed($urandom_range(0, 2 * span)) - span) >>> 1);
				y = 16'(($signed($urandom_range(0, 2 * span)) - span) >>> 1);
			end else begin
				x = 16'($urandom);
				y = 16'($urandom);
			end
			case (phase)
				0: write_all(x, y, l1, l2, 16'd0, 16'd0);
				1: write_all(16'h8000, 16'h7FFF, 16'h3FFF, 16'h3FFF, 16'hFFFF, 16'hFFFF);
				default: write_all(x, y, l1, l2, 16'($urandom), 16'($urandom));
			endcase
			idling_on = (phase != 3);
			for (int i = 0; i < 100; i++)
				send_word(any_angle(), any_angle());
			drain_results();
		end
		idling_on = 1'b1;
	endtask

	// result checker and receiver stall
	always @(posedge clk) begin
		joint_result_t want, got;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				got = '{shoulder_torque, elbow_torque, shoulder_target, elbow_target,
				        target_reachable};
				if (pending_results.size() == 0) begin
					$display("%0t: result word with nothing expected", $time);
					error_count++;
				end else begin
					want = pending_results.pop_front();
					words_checked++;
					if (want.reachable) reachable_seen++;
					else unreachable_seen++;
					if (got.shoulder_torque !== want.shoulder_torque) begin
						$display("%0t: shoulder_torque exp %0d got %0d", $time,
						         want.shoulder_torque, got.shoulder_torque);
						error_count++;
					end
					if (got.elbow_torque !== want.elbow_torque) begin
						$display("%0t: elbow_torque exp %0d got %0d", $time,
						         want.elbow_torque, got.elbow_torque);
						error_count++;
					end
					if (got.shoulder_target !== want.shoulder_target) begin
						$display("%0t: shoulder_target exp %0d got %0d", $time,
						         want.shoulder_target, got.shoulder_target);
						error_count++;
					end
					if (got.elbow_target !== want.elbow_target) begin
						$display("%0t: elbow_target exp %0d got %0d", $time,
						         want.elbow_target, got.elbow_target);
						error_count++;
					end
					if (got.reachable !== want.reachable) begin
						$display("%0t: target_reachable exp %0b got %0b", $time,
						         want.reachable, got.reachable);
						error_count++;
					end
				end
			end
			// long hold-off counted here, otherwise random stalls
			if (hold_request) begin
				hold_request = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= idling_on && ($urandom_range(99) < 29);
			end
		end
	end

	// watchdog on cycles without any accepted word or delivered result
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || !arst_n)
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		shoulder_angle = '0;
		elbow_angle = '0;
		out_stall = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		error_count = 0;
		words_sent = 0;
		words_checked = 0;
		reachable_seen = 0;
		unreachable_seen = 0;
		idling_on = 1'b1;
		hold_request = 1'b0;
		hold_left = 0;
		quiet_cycles = 0;
		// reset values of the registers and history
		point_x = 16'sd3277;
		point_y = 16'sd0;
		upper_len = 14'd1638;
		lower_len = 14'd1638;
		kp_gain = 14'd2560;
		kd_gain = 14'd256;
		last_shoulder = '0;
		last_elbow = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_angle_extremes();
		test_special_points();
		test_backpressure();
		test_random_phases();

		drain_results();
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("covered %0d words, %0d results checked (%0d reachable, %0d out of reach)",
		         words_sent, words_checked, reachable_seen, unreachable_seen);
		$display("register sweeps incl. zero links, origin, gain extremes, long output hold");
		if (error_count == 0 && pending_results.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
